>>> sv/hda_pkg.sv
package hda_pkg;

    localparam int LAT_W = 28;
    localparam int LON_W = 29;
    localparam int RAD_W = 23;
    localparam int SEG_W = 33;
    localparam int TOT_W = 48;
    localparam int ANG_TABLE_LEN = 40;
    localparam int DEFAULT_ITERATIONS = 24;
    localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd6371000;
    localparam logic signed [LAT_W-1:0] LAT_MAX = 28'sd94371840;
    localparam logic signed [LON_W-1:0] LON_MAX = 29'sd188743680;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [35:0] CORDIC_K = 36'sd652032874;
    localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;
    localparam logic [31:0] PI_Q29 = 32'd1686629713;

    // floor(2^44/360), estimate of floor(n/360) for n < 2^41 is low by at most one
    localparam logic [35:0] RECIP_360 = 36'd48867183456;

    function automatic logic signed [35:0] ang_entry(input logic [5:0] i);
        logic signed [35:0] v;
        begin
            case (i)
                6'd0: v = 36'sh020000000;
                6'd1: v = 36'sh012E4051E;
                6'd2: v = 36'sh009FB385B;
                6'd3: v = 36'sh0051111D4;
                6'd4: v = 36'sh0028B0D43;
                6'd5: v = 36'sh00145D7E1;
                6'd6: v = 36'sh000A2F61E;
                6'd7: v = 36'sh000517C55;
                6'd8: v = 36'sh00028BE53;
                6'd9: v = 36'sh000145F2F;
                6'd10: v = 36'sh0000A2F98;
                6'd11: v = 36'sh0000517CC;
                6'd12: v = 36'sh000028BE6;
                6'd13: v = 36'sh0000145F3;
                6'd14: v = 36'sh00000A2FA;
                6'd15: v = 36'sh00000517D;
                6'd16: v = 36'sh0000028BE;
                6'd17: v = 36'sh00000145F;
                6'd18: v = 36'sh000000A30;
                6'd19: v = 36'sh000000518;
                6'd20: v = 36'sh00000028C;
                6'd21: v = 36'sh000000146;
                6'd22: v = 36'sh0000000A3;
                6'd23: v = 36'sh000000051;
                6'd24: v = 36'sh000000029;
                6'd25: v = 36'sh000000014;
                6'd26: v = 36'sh00000000A;
                6'd27: v = 36'sh000000005;
                6'd28: v = 36'sh000000003;
                6'd29: v = 36'sh000000001;
                6'd30: v = 36'sh000000001;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> sv/haversine_distance_accumulator.sv
// Haversine distance accumulator. Each request is one position fix; the block
// returns the great-circle distance from the previous fix (1/256 m) and a
// saturating running total. A start request clears the total and reports zero.
// With N = CORDIC_ITERATIONS (capped at 40) a request that needs a distance
// keeps the input side busy through four rotation passes (angle scaling,
// divide by 360 through a reciprocal multiply, fold, N steps, done), four
// multiply steps, two bit-serial square roots of 31 steps, one vectoring pass
// and three scaling multiply steps, all through one shared 36x36-bit multiplier
// and one CORDIC unit, then the handoff of the result to the output register.
// Fixes that need no distance go straight to that handoff. A result waiting in
// the output register does not block the next request; it only holds the
// handoff of the one after it. The user must write earth_radius only when
// idle; the block itself does not enforce it.
module haversine_distance_accumulator #(
    parameter int CORDIC_ITERATIONS = hda_pkg::DEFAULT_ITERATIONS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hda_pkg::RAD_W-1:0]   cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata, // latitude[27:0], longitude[56:28]
    input  logic                        s_axis_tuser, // track_start
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [87:0]                 m_axis_tdata  // segment_distance[32:0], total[80:33]
);
    import hda_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_TURN  = 5'd1;
    localparam logic [4:0] S_DIV   = 5'd2;
    localparam logic [4:0] S_DIVF  = 5'd3;
    localparam logic [4:0] S_CSTRT = 5'd4;
    localparam logic [4:0] S_CWAIT = 5'd5;
    localparam logic [4:0] S_SQ1   = 5'd6;
    localparam logic [4:0] S_SQ2   = 5'd7;
    localparam logic [4:0] S_SQ3   = 5'd8;
    localparam logic [4:0] S_SQ4   = 5'd9;
    localparam logic [4:0] S_SQRT  = 5'd10;
    localparam logic [4:0] S_VSTRT = 5'd11;
    localparam logic [4:0] S_VWAIT = 5'd12;
    localparam logic [4:0] S_P1    = 5'd13;
    localparam logic [4:0] S_P2    = 5'd14;
    localparam logic [4:0] S_P3    = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;
    localparam logic [4:0] S_HOLD  = 5'd17;

    logic [4:0] state_reg;
    logic [RAD_W-1:0] radius_reg;
    logic signed [LAT_W-1:0] plat_reg, lat_reg;
    logic signed [LON_W-1:0] plon_reg, lon_reg;
    logic [TOT_W-1:0] total_reg;
    logic have_reg;
    logic [1:0] k_reg;
    logic signed [35:0] s1_reg, s2_reg, c1_reg, c2_reg, a_reg, t_reg;
    logic [31:0] th_reg;
    logic neg_reg;
    logic [SEG_W-1:0] seg_reg;
    logic out_valid_reg;
    logic [TOT_W+SEG_W-1:0] out_data_reg;
    logic [63:0] acc_reg;
    logic [63:0] rem_reg, root_reg, bit_reg;
    logic sq_second_reg;
    logic signed [35:0] sy_reg;

    // input unpack and clamp
    logic signed [LAT_W-1:0] in_lat, lat_c;
    logic signed [LON_W-1:0] in_lon, lon_c;
    assign in_lat = s_axis_tdata[27:0];
    assign in_lon = s_axis_tdata[56:28];
    assign lat_c = (in_lat > LAT_MAX) ? LAT_MAX : ((in_lat < -LAT_MAX) ? -LAT_MAX : in_lat);
    assign lon_c = (in_lon > LON_MAX) ? LON_MAX : ((in_lon < -LON_MAX) ? -LON_MAX : in_lon);

    // angle source for pass k
    logic signed [30:0] dsrc;
    logic shift12;
    always_comb
    begin
        case (k_reg)
            2'd0: begin dsrc = 31'(lat_reg) - 31'(plat_reg); shift12 = 1'b0; end
            2'd1: begin dsrc = 31'(lon_reg) - 31'(plon_reg); shift12 = 1'b0; end
            2'd2: begin dsrc = 31'(plat_reg); shift12 = 1'b1; end
            default: begin dsrc = 31'(lat_reg); shift12 = 1'b1; end
        endcase
    end
    logic [30:0] dmag;
    assign dmag = dsrc[30] ? 31'(-dsrc) : 31'(dsrc);

    // shared multiplier, operands chosen per state
    logic [35:0] mul_a, mul_b;
    logic [71:0] mul_p;
    logic mul_sneg;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_sneg = 1'b0;
        case (state_reg)
            S_DIV: begin mul_a = acc_reg[40:5]; mul_b = RECIP_360; end
            S_SQ1: begin mul_a = 36'(s1_reg[35] ? -s1_reg : s1_reg); mul_b = mul_a; end
            S_SQ2: begin mul_a = 36'(s2_reg[35] ? -s2_reg : s2_reg); mul_b = mul_a; end
            S_SQ3: begin
                mul_a = 36'(c1_reg[35] ? -c1_reg : c1_reg);
                mul_b = 36'(c2_reg[35] ? -c2_reg : c2_reg);
                mul_sneg = c1_reg[35] ^ c2_reg[35];
            end
            S_SQ4: begin
                mul_a = 36'(t_reg[35] ? -t_reg : t_reg);
                mul_b = 36'(c1_reg);
                mul_sneg = t_reg[35];
            end
            S_P1: begin mul_a = 36'(radius_reg); mul_b = 36'(a_reg); end
            S_P2: begin mul_a = 36'(acc_reg[63:26]); mul_b = 36'(PI_Q29); end
            S_P3: begin mul_a = 36'(acc_reg[25:0]); mul_b = 36'(PI_Q29); end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // signed product >> 30 with floor
    logic [71:0] mul_sh;
    logic signed [71:0] mul_s30;
    assign mul_sh = mul_p >> 30;
    assign mul_s30 = mul_sneg ? ((mul_p[29:0] != 0) ? -$signed(mul_sh) - 72'sd1
                                                    : -$signed(mul_sh))
                              : $signed(mul_sh);

    // fold into [-90, 90) degrees before rotation
    logic th_fold;
    logic [31:0] th_rot;
    assign th_fold = th_reg[31:30] inside {2'b01, 2'b10};
    assign th_rot = th_fold ? th_reg + 32'h8000_0000 : th_reg;

    // cordic unit
    logic cor_start, cor_vec, cor_done;
    logic signed [35:0] cx_in, cy_in, cz_in, cx, cy, cz;
    hda_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cor_start), .vectoring(cor_vec),
        .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
        .done(cor_done), .x_out(cx), .y_out(cy), .z_out(cz)
    );
    assign cor_start = (state_reg == S_CSTRT) || (state_reg == S_VSTRT);
    assign cor_vec = (state_reg == S_VSTRT) || (state_reg == S_VWAIT);
    assign cx_in = (state_reg == S_VSTRT) ? $signed(36'(root_reg)) : CORDIC_K;
    assign cy_in = (state_reg == S_VSTRT) ? sy_reg : '0;
    assign cz_in = (state_reg == S_VSTRT) ? '0 : {{4{th_rot[31]}}, th_rot};

    logic [63:0] turn_n;
    assign turn_n = shift12 ? ((64'(dmag) << 12) + 64'd180) : ((64'(dmag) << 11) + 64'd180);

    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            radius_reg <= RADIUS_RESET;
            plat_reg <= '0;
            plon_reg <= '0;
            total_reg <= '0;
            have_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                radius_reg <= cfg_wdata;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= {total_reg, seg_reg};
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (s_axis_tvalid)
                    begin
                        lat_reg <= lat_c;
                        lon_reg <= lon_c;
                        if (s_axis_tuser || !have_reg)
                        begin
                            if (s_axis_tuser)
                                total_reg <= '0;
                            seg_reg <= '0;
                            plat_reg <= lat_c;
                            plon_reg <= lon_c;
                            have_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            k_reg <= 2'd0;
                            state_reg <= S_TURN;
                        end
                    end
                S_TURN:
                begin
                    acc_reg <= turn_n;
                    neg_reg <= dsrc[30];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // quotient estimate, low by at most one
                    t_reg <= 36'(mul_p[71:39]);
                    state_reg <= S_DIVF;
                end
                S_DIVF:
                begin : divf
                    logic [63:0] q;
                    logic [63:0] r;
                    logic [31:0] qq;
                    q = 64'(t_reg[35:0]);
                    r = acc_reg - q * 64'd360;
                    qq = 32'(q);
                    if (r >= 64'd360)
                        qq = qq + 32'd1;
                    th_reg <= neg_reg ? 32'(-qq) : qq;
                    state_reg <= S_CSTRT;
                end
                S_CSTRT:
                begin
                    neg_reg <= th_fold;
                    state_reg <= S_CWAIT;
                end
                S_CWAIT:
                    if (cor_done)
                    begin
                        case (k_reg)
                            2'd0: s1_reg <= neg_reg ? -cy : cy;
                            2'd1: s2_reg <= neg_reg ? -cy : cy;
                            2'd2: c1_reg <= neg_reg ? -cx : cx;
                            default: c2_reg <= neg_reg ? -cx : cx;
                        endcase
                        if (k_reg == 2'd3)
                            state_reg <= S_SQ1;
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                            state_reg <= S_TURN;
                        end
                    end
                S_SQ1:
                begin
                    s1_reg <= 36'(mul_s30);
                    state_reg <= S_SQ2;
                end
                S_SQ2:
                begin
                    s2_reg <= 36'(mul_s30);
                    state_reg <= S_SQ3;
                end
                S_SQ3:
                begin
                    t_reg <= 36'(mul_s30);
                    c1_reg <= s2_reg;
                    state_reg <= S_SQ4;
                end
                S_SQ4:
                begin : sq4
                    logic signed [36:0] s;
                    s = 37'(s1_reg) + 37'(mul_s30);
                    if (s < 0)
                        a_reg <= '0;
                    else if (s > 37'(Q30_ONE))
                        a_reg <= Q30_ONE;
                    else
                        a_reg <= 36'(s);
                    rem_reg <= '0;
                    sq_second_reg <= 1'b0;
                    bit_reg <= 64'd1 << 60;
                    root_reg <= '0;
                    state_reg <= S_SQRT;
                    acc_reg <= '0;
                end
                S_SQRT:
                begin : sq
                    logic [63:0] v;
                    logic [63:0] r;
                    v = (bit_reg == (64'd1 << 60)) ?
                        (sq_second_reg ? (64'(Q30_ONE - a_reg) << 30) : (64'(a_reg) << 30))
                        : rem_reg;
                    r = (bit_reg == (64'd1 << 60)) ? 64'd0 : root_reg;
                    if (v >= r + bit_reg)
                    begin
                        rem_reg <= v - (r + bit_reg);
                        root_reg <= (r >> 1) + bit_reg;
                    end
                    else
                    begin
                        rem_reg <= v;
                        root_reg <= r >> 1;
                    end
                    if (bit_reg == 64'd1)
                    begin
                        if (!sq_second_reg)
                        begin
                            sy_reg <= (v >= r + bit_reg) ? 36'((r >> 1) + bit_reg)
                                                         : 36'(r >> 1);
                            sq_second_reg <= 1'b1;
                            bit_reg <= 64'd1 << 60;
                        end
                        else
                        begin
                            bit_reg <= bit_reg >> 2;
                            state_reg <= S_VSTRT;
                        end
                    end
                    else
                        bit_reg <= bit_reg >> 2;
                end
                S_VSTRT:
                begin
                    th_reg <= '0;
                    state_reg <= S_VWAIT;
                end
                S_VWAIT:
                    if (cor_done)
                    begin
                        if (cz < 0)
                            a_reg <= '0;
                        else if (cz > Q30_ONE)
                            a_reg <= Q30_ONE;
                        else
                            a_reg <= cz;
                        state_reg <= S_P1;
                    end
                S_P1:
                begin
                    acc_reg <= 64'(mul_p);
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    seg_reg <= '0;
                    rem_reg <= 64'(mul_p);
                    state_reg <= S_P3;
                end
                S_P3:
                begin : p3
                    logic [63:0] s;
                    logic [SEG_W-1:0] seg;
                    logic [TOT_W:0] sum;
                    s = (rem_reg + 64'(mul_p >> 26) + (64'd1 << 24)) >> 25;
                    seg = s[SEG_W-1:0];
                    seg_reg <= seg;
                    sum = {1'b0, total_reg} + 49'(seg);
                    total_reg <= sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
                    plat_reg <= lat_reg;
                    plon_reg <= lon_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_load)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_data_reg};

endmodule

>>> sv/hda_cordic.sv
module hda_cordic #(
    parameter int ITERATIONS = hda_pkg::DEFAULT_ITERATIONS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                vectoring,
    input  logic signed [35:0]  x_in,
    input  logic signed [35:0]  y_in,
    input  logic signed [35:0]  z_in,
    output logic                done,
    output logic signed [35:0]  x_out,
    output logic signed [35:0]  y_out,
    output logic signed [35:0]  z_out
);
    import hda_pkg::*;

    localparam int N = (ITERATIONS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : ITERATIONS;

    logic signed [35:0] x_reg, y_reg, z_reg;
    logic [5:0] i_reg;
    logic busy_reg, done_reg;
    logic dir;
    logic signed [35:0] xs, ys, ang;

    assign dir = vectoring ? (y_reg >= 0) : (z_reg >= 0);
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign ang = ang_entry(i_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (i_reg == 6'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                i_reg <= i_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (busy_reg)
        begin
            if (dir)
            begin
                if (vectoring)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
            end
            else
            begin
                if (vectoring)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end
            end
        end
    end

    assign done = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

>>> sim/haversine_distance_accumulator_tb.sv
module haversine_distance_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hda_pkg::*;

    localparam int ITERS = (DEFAULT_ITERATIONS > 40) ? 40 : DEFAULT_ITERATIONS;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [TOT_W-1:0] total;
    } leg_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [RAD_W-1:0]  cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;   // latitude[27:0], longitude[56:28]
    logic              s_axis_tuser;   // track_start
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [87:0]       m_axis_tdata;   // segment_distance[32:0], trip_sum[80:33]

    leg_t   expected_legs[$];
    int     failures;
    int     idle_cycles;
    longint atan_turns[40];

    // predictor state
    logic [RAD_W-1:0]  radius_m;
    longint            last_lat;
    longint            last_lon;
    logic [TOT_W-1:0]  trip_total;
    bit                have_fix;

    haversine_distance_accumulator dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [31:0] deg_to_turns(input longint du, input int shift);
        longint mag;
        longint r;
        mag = (du < 0) ? -du : du;
        r = ((mag << shift) + 180) / 360;
        return (du < 0) ? 32'(-r) : 32'(r);
    endfunction

    function automatic void sincos_q30(input logic [31:0] th, output longint s,
                                       output longint c);
        longint x;
        longint y;
        longint z;
        longint xn;
        bit     flip;
        flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
        if (flip)
            th = th + 32'h8000_0000;
        z = longint'($signed(th));
        x = longint'(CORDIC_K);
        y = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_turns[i];
            end
            else
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_turns[i];
            end
            x = xn;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [SEG_W-1:0] great_circle(input longint lat, input longint lon);
        longint s1, s2, c1, c2, unused, a, x, y, z, xn;
        longint unsigned prod, hi, lo;
        sincos_q30(deg_to_turns(lat - last_lat, 11), s1, unused);
        sincos_q30(deg_to_turns(lon - last_lon, 11), s2, unused);
        sincos_q30(deg_to_turns(last_lat, 12), unused, c1);
        sincos_q30(deg_to_turns(lat, 12), unused, c2);
        a = ((s1 * s1) >>> 30) + ((((c1 * c2) >>> 30) * ((s2 * s2) >>> 30)) >>> 30);
        a = clip(a, 0, 64'd1 << 30);
        y = floor_sqrt(longint'(a) << 30);
        x = floor_sqrt(((64'd1 << 30) - a) << 30);
        z = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            if (y >= 0)
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_turns[i];
            end
            else
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_turns[i];
            end
            x = xn;
        end
        z = clip(z, 0, 64'd1 << 30);
        prod = longint'(radius_m) * z;
        hi = prod >> 26;
        lo = prod & ((64'd1 << 26) - 1);
        return SEG_W'((hi * PI_Q29 + ((lo * PI_Q29) >> 26) + (64'd1 << 24)) >> 25);
    endfunction

    function automatic leg_t predict_leg(input logic [27:0] lat_raw,
                                         input logic [28:0] lon_raw, input bit start);
        leg_t   leg;
        longint lat;
        longint lon;
        lat = clip(longint'($signed(lat_raw)), -longint'(LAT_MAX), longint'(LAT_MAX));
        lon = clip(longint'($signed(lon_raw)), -longint'(LON_MAX), longint'(LON_MAX));
        leg.seg = '0;
        if (start)
            trip_total = '0;
        else if (have_fix)
        begin
            leg.seg = great_circle(lat, lon);
            if (trip_total > TOTAL_MAX - TOT_W'(leg.seg))
                trip_total = TOTAL_MAX;
            else
                trip_total = trip_total + TOT_W'(leg.seg);
        end
        last_lat = lat;
        last_lon = lon;
        have_fix = 1'b1;
        leg.total = trip_total;
        return leg;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic send_fix(input logic [27:0] lat_raw, input logic [28:0] lon_raw,
                            input bit start);
        repeat (pick_gap()) @(negedge clk);
        s_axis_tdata = {7'd0, lon_raw, lat_raw};
        s_axis_tuser = start;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_legs.push_back(predict_leg(lat_raw, lon_raw, start));
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic set_radius(input logic [RAD_W-1:0] r);
        while (expected_legs.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_wdata = r;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        radius_m = r;
    endtask

    task automatic test_extremes();
        send_fix(28'd0, 29'd0, 1'b0);
        send_fix(28'(LAT_MAX), 29'(LON_MAX), 1'b0);
        send_fix(28'(-LAT_MAX), 29'(-LON_MAX), 1'b0);
        send_fix(28'(-LAT_MAX), 29'(-LON_MAX), 1'b0);
        send_fix(28'h800_0000, 29'h1000_0000, 1'b0);
        send_fix(28'h7FF_FFFF, 29'h0FFF_FFFF, 1'b0);
        send_fix(28'd0, 29'(LON_MAX), 1'b1);
        send_fix(28'd0, 29'(-LON_MAX), 1'b0);
        send_fix(28'd1, 29'(-LON_MAX + 1), 1'b0);
        send_fix(28'hFFF_FFFF, 29'h1FFF_FFFF, 1'b0);
        send_fix(28'h555_5555, 29'h0AAA_AAAA, 1'b0);
        send_fix(28'hAAA_AAAA, 29'h1555_5555, 1'b0);
        send_fix(28'd0, 29'd0, 1'b1);
    endtask

    task automatic test_radius_range();
        logic [RAD_W-1:0] radii[4];
        radii = '{23'd0, 23'd1, 23'h7F_FFFF, RADIUS_RESET};
        foreach (radii[k])
        begin
            set_radius(radii[k]);
            send_fix(28'd0, 29'd0, 1'b1);
            send_fix(28'(LAT_MAX / 2), 29'(LON_MAX), 1'b0);
            send_fix(28'(-LAT_MAX), 29'd12345, 1'b0);
            send_fix(28'(-LAT_MAX + 3), 29'd12346, 1'b0);
        end
    endtask

    task automatic test_random_tracks(input int count);
        longint lat;
        longint lon;
        longint step;
        int     r;
        lat = 0;
        lon = 0;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                lat = $urandom_range(0, 2 * LAT_MAX) - longint'(LAT_MAX);
                lon = $urandom_range(0, 2 * LON_MAX) - longint'(LON_MAX);
                send_fix(28'(lat), 29'(lon), 1'b1);
            end
            else if (r < 15)
                send_fix(28'($urandom), 29'($urandom), 1'($urandom));
            else
            begin
                step = longint'(1) << $urandom_range(0, 26);
                lat = clip(lat + longint'($urandom_range(0, 2 * step)) - step,
                           -longint'(LAT_MAX), longint'(LAT_MAX));
                lon = lon + longint'($urandom_range(0, 2 * step)) - step;
                if (lon > longint'(LON_MAX))
                    lon = lon - 2 * longint'(LON_MAX);
                if (lon < -longint'(LON_MAX))
                    lon = lon + 2 * longint'(LON_MAX);
                send_fix(28'(lat), 29'(lon), 1'b0);
            end
            if (n % 500 == 499)
                set_radius((n % 1000 == 999) ? RADIUS_RESET : 23'($urandom_range(1, 8388607)));
        end
    endtask

    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) < 97 || !rst_n)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= 1'b0;
    end

    always @(posedge clk)
    begin
        leg_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_legs.size() == 0)
            begin
                $error("unexpected result, data %h", m_axis_tdata);
                failures++;
            end
            else
            begin
                want = expected_legs.pop_front();
                if (m_axis_tdata[32:0] !== want.seg)
                begin
                    $error("segment_distance expected %0d got %0d", want.seg,
                           m_axis_tdata[32:0]);
                    failures++;
                end
                if (m_axis_tdata[80:33] !== want.total)
                begin
                    $error("trip_sum expected %0d got %0d", want.total,
                           m_axis_tdata[80:33]);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        atan_turns = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
            32'h00000001, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        failures = 0;
        idle_cycles = 0;
        radius_m = RADIUS_RESET;
        last_lat = 0;
        last_lon = 0;
        trip_total = '0;
        have_fix = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_extremes();
        test_radius_range();
        test_random_tracks(2000);

        while (expected_legs.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
